// ----- rtl/core/image_convolution_clamp_top_defines.svh -----
// Assertion macros for the convolution block
`ifndef IMAGE_CONVOLUTION_CLAMP_TOP_DEFINES_SVH
`define IMAGE_CONVOLUTION_CLAMP_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define ICC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ICC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ICC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ICC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/icc_pkg.sv -----
package icc_pkg;
  localparam int KernelDim = 3;
  localparam int MaxWidth  = 2048;
  localparam int Kc        = KernelDim / 2;
  localparam int LineSlots = KernelDim - 1;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int SumW      = 24;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_SCALE  = 3'd2,
    REG_KROW0  = 3'd3,
    REG_KROW1  = 3'd4,
    REG_KROW2  = 3'd5,
    REG_KROW3  = 3'd6,
    REG_KROW4  = 3'd7
  } reg_idx_t;

  // one column of the window, top row first
  typedef logic [KernelDim-1:0][7:0] column_t;
  // per-cell controls
  typedef struct packed {
    logic             shift;
    logic [KernelDim-1:0] row_ok;
  } cell_ctrl_t;
endpackage

// ----- rtl/core/icc_if.sv -----
interface icc_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] pixel_in;
  modport source (output valid, mode, pixel_in, input ready);
  modport sink (input valid, mode, pixel_in, output ready);
endinterface

interface icc_out_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic       frame_last;
  modport source (output valid, pixel_out, frame_last, input ready);
  modport sink (input valid, pixel_out, frame_last, output ready);
endinterface

interface icc_cfg_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [39:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/icc_ram.sv -----
module icc_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/icc_cell.sv -----
// One window column: takes the column from its right neighbor on shift and
// forms its masked tap products against its own coefficient column.
module icc_cell (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  icc_pkg::cell_ctrl_t                    ctrl,
  input  logic                                   col_ok,
  input  icc_pkg::column_t                       col_in,
  input  logic [icc_pkg::KernelDim-1:0][7:0]     coefs,
  output icc_pkg::column_t                       col_r,
  output logic signed [icc_pkg::SumW-1:0]        part
);
  icc_pkg::column_t col_nxt;

  // advance column on shift
  always_comb col_nxt = ctrl.shift ? col_in : col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) col_r <= '0;
    else col_r <= col_nxt;
  end

  // sum the column taps that lie inside the image
  always_comb begin
    logic signed [icc_pkg::SumW-1:0] acc;
    acc = '0;
    for (int i = 0; i < icc_pkg::KernelDim; i++) begin
      if (col_ok && ctrl.row_ok[i])
        acc = acc + icc_pkg::SumW'($signed({1'b0, col_r[i]}) * $signed(coefs[i]));
    end
    part = acc;
  end
endmodule

// ----- rtl/core/image_convolution_clamp_top.sv -----
// Pipeline: the pixel completing a result passes the line RAM read, window shift,
//   tap sum and scale registers before the result can be taken.
// Throughput: one item per cycle; the whole pipeline holds only while a result
//   waits in the output register and the scale stage is full.
// Reset: rst_n synchronous active low clears counters, window and valid bits and sets
//   configuration registers to defaults; line RAM content is undefined until written.
`include "image_convolution_clamp_top_defines.svh"
module image_convolution_clamp_top (
  input logic clk,
  input logic rst_n,
  icc_in_if.sink   in_ch,
  icc_out_if.source out_ch,
  icc_cfg_if.sink  cfg_ch
);
  localparam int KD = icc_pkg::KernelDim;
  localparam int CW = icc_pkg::ColW;
  localparam int SW = icc_pkg::SumW;
  localparam int AW = $clog2(icc_pkg::LineSlots * icc_pkg::MaxWidth);

  // configuration registers
  logic [11:0] width_r;
  logic [15:0] height_r, scale_r;
  logic [4:0][39:0] krow_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 12'd640; height_r <= 16'd480; scale_r <= 16'd256;
      krow_r[0] <= 40'd16776447; krow_r[1] <= 40'd16520444;
      krow_r[2] <= 40'd16776447; krow_r[3] <= '0; krow_r[4] <= '0;
    end else if (cfg_ch.valid) begin
      unique case (icc_pkg::reg_idx_t'(cfg_ch.index))
        icc_pkg::REG_WIDTH:  width_r <= cfg_ch.data[11:0];
        icc_pkg::REG_HEIGHT: height_r <= cfg_ch.data[15:0];
        icc_pkg::REG_SCALE:  scale_r <= cfg_ch.data[15:0];
        icc_pkg::REG_KROW0:  krow_r[0] <= cfg_ch.data;
        icc_pkg::REG_KROW1:  krow_r[1] <= cfg_ch.data;
        icc_pkg::REG_KROW2:  krow_r[2] <= cfg_ch.data;
        icc_pkg::REG_KROW3:  krow_r[3] <= cfg_ch.data;
        icc_pkg::REG_KROW4:  krow_r[4] <= cfg_ch.data;
        default: ;
      endcase
    end
  end
  assign cfg_ch.ready = 1'b1;

  // effective sizes
  logic [12:0] w_eff;
  logic [15:0] h_eff;
  always_comb begin
    if (width_r == '0) w_eff = 13'd1;
    else if (13'(width_r) > 13'(icc_pkg::MaxWidth)) w_eff = 13'(icc_pkg::MaxWidth);
    else w_eff = 13'(width_r);
    h_eff = (height_r == '0) ? 16'd1 : height_r;
  end

  // pipeline valid bits and stall
  logic s1_r, s2_r, s3_r, ov_r;
  logic s1_nxt, s2_nxt, s3_nxt, ov_nxt;
  logic adv;
  assign adv = !ov_r || out_ch.ready || !s3_r;

  // input raster counters and output counters
  logic [CW:0]  in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [16:0]  in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic done, take, emit, last;
  logic [CW:0] col, ocol;
  logic [7:0] v;
  logic [$clog2(icc_pkg::LineSlots)-1:0] slot_w;
  logic [icc_pkg::LineSlots-1:0][$clog2(icc_pkg::LineSlots)-1:0] slot_r;
  logic [icc_pkg::LineSlots-1:0] rd_ok;
  logic [KD-1:0] orow_ok;
  logic [KD-1:0] ocol_ok;
  logic [29:0] pos_in, pos_lim;

  assign in_ch.ready = adv;
  assign take = in_ch.valid && adv;
  assign done = in_row_r >= 17'(h_eff);

  always_comb begin
    col = (in_col_r >= 12'(w_eff)) ? 12'(w_eff - 13'd1) : in_col_r;
    ocol = (out_col_r >= 12'(w_eff)) ? 12'(w_eff - 13'd1) : out_col_r;
    v = done ? 8'd0 : in_ch.pixel_in;
    slot_w = $bits(slot_w)'(in_row_r % icc_pkg::LineSlots);
    for (int i = 0; i < icc_pkg::LineSlots; i++) begin
      slot_r[i] = $bits(slot_w)'((in_row_r + 17'(i)) % icc_pkg::LineSlots);
      rd_ok[i] = (in_row_r + 17'(i) >= 17'(icc_pkg::LineSlots))
                 && (in_row_r + 17'(i) < 17'(h_eff) + 17'(icc_pkg::LineSlots));
    end
    pos_in = 30'(in_row_r) * 30'(w_eff) + 30'(col);
    pos_lim = 30'(icc_pkg::Kc) * 30'(w_eff) + 30'(icc_pkg::Kc);
    emit = pos_in >= pos_lim;
    last = (out_row_r >= 17'(h_eff) - 17'd1) && (ocol >= 12'(w_eff) - 12'd1);
    for (int i = 0; i < KD; i++) begin
      orow_ok[i] = (out_row_r + 17'(i) >= 17'(icc_pkg::Kc))
                   && (out_row_r + 17'(i) < 17'(h_eff) + 17'(icc_pkg::Kc));
      ocol_ok[i] = (13'(ocol) + 13'(i) >= 13'(icc_pkg::Kc))
                   && (13'(ocol) + 13'(i) < w_eff + 13'(icc_pkg::Kc));
    end
  end

  logic step;
  assign step = take && !(in_ch.mode && !done);

  // advance the raster counters
  always_comb begin
    in_col_nxt = in_col_r; in_row_nxt = in_row_r;
    out_col_nxt = out_col_r; out_row_nxt = out_row_r;
    if (step) begin
      if (emit && last) begin
        in_col_nxt = '0; in_row_nxt = '0; out_col_nxt = '0; out_row_nxt = '0;
      end else begin
        if (emit) begin
          if (13'(ocol) + 13'd1 >= w_eff) begin
            out_col_nxt = '0; out_row_nxt = out_row_r + 17'd1;
          end else out_col_nxt = ocol + 12'd1;
        end
        if (13'(col) + 13'd1 >= w_eff) begin
          in_col_nxt = '0; in_row_nxt = in_row_r + 17'd1;
        end else in_col_nxt = col + 12'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0; in_row_r <= '0; out_col_r <= '0; out_row_r <= '0;
    end else begin
      in_col_r <= in_col_nxt; in_row_r <= in_row_nxt;
      out_col_r <= out_col_nxt; out_row_r <= out_row_nxt;
    end
  end

  // line RAMs, one copy per read row, each holding every buffered row
  logic [icc_pkg::LineSlots-1:0][7:0] rd_data;
  logic [AW-1:0] waddr;
  assign waddr = AW'(slot_w) * AW'(icc_pkg::MaxWidth) + AW'(col);
  for (genvar g = 0; g < icc_pkg::LineSlots; g++) begin : g_line
    icc_ram #(.Width(8), .Depth(icc_pkg::LineSlots * icc_pkg::MaxWidth)) u_ram (
      .clk, .we(step), .waddr,
      .wdata(v),
      .raddr(AW'(slot_r[g]) * AW'(icc_pkg::MaxWidth) + AW'(col)),
      .rdata(rd_data[g])
    );
  end

  // hold the read data while stage 1 waits, the RAM output moves on
  logic rd_fresh_r;
  logic [icc_pkg::LineSlots-1:0][7:0] rd_hold_r;
  always_ff @(posedge clk) begin
    if (!rst_n) rd_fresh_r <= 1'b0;
    else rd_fresh_r <= step;
  end
  always_ff @(posedge clk) begin
    if (rd_fresh_r) rd_hold_r <= rd_data;
  end

  // stage 1 holding register
  logic [icc_pkg::LineSlots-1:0] s1_ok_r;
  logic [7:0] s1_pix_r;
  logic s1_emit_r, s1_last_r;
  logic [KD-1:0] s1_rok_r, s1_cok_r;
  always_ff @(posedge clk) begin
    if (step) begin
      s1_ok_r <= rd_ok; s1_pix_r <= v; s1_emit_r <= emit && (step);
      s1_last_r <= last; s1_rok_r <= orow_ok; s1_cok_r <= ocol_ok;
    end
  end

  // window column into the chain
  icc_pkg::column_t new_col;
  always_comb begin
    for (int i = 0; i < icc_pkg::LineSlots; i++)
      new_col[i] = s1_ok_r[i] ? (rd_fresh_r ? rd_data[i] : rd_hold_r[i]) : 8'd0;
    new_col[KD-1] = s1_pix_r;
  end

  // stage 2 flags follow the window
  logic s2_last_r;
  logic [KD-1:0] s2_cok_r;
  logic [KD-1:0] s2_rok_r;

  icc_pkg::cell_ctrl_t ctrl;
  assign ctrl.shift = s1_r && adv;
  assign ctrl.row_ok = s2_rok_r;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      s2_last_r <= s1_last_r;
      s2_cok_r <= s1_cok_r; s2_rok_r <= s1_rok_r;
    end
  end

  // chain of cells: cell KD-1 takes the new column
  icc_pkg::column_t [KD-1:0] cols;
  logic signed [KD-1:0][SW-1:0] parts;
  logic [KD-1:0][KD-1:0][7:0] cc;
  always_comb begin
    for (int j = 0; j < KD; j++)
      for (int i = 0; i < KD; i++)
        cc[j][i] = krow_r[KD-1-i][8*(KD-1-j) +: 8];
  end
  for (genvar j = 0; j < KD; j++) begin : g_cell
    icc_cell u_cell (
      .clk, .rst_n, .ctrl,
      .col_ok(s2_cok_r[j]),
      .col_in((j == KD-1) ? new_col : cols[(j == KD-1) ? j : j+1]),
      .coefs(cc[j]),
      .col_r(cols[j]),
      .part(parts[j])
    );
  end

  // sum the cell outputs
  logic signed [SW-1:0] sum;
  always_comb begin
    sum = '0;
    for (int j = 0; j < KD; j++) sum = sum + parts[j];
  end

  // register the sum ahead of the scale multiplier
  logic signed [SW-1:0] sum_r;
  logic s3_last_r;
  always_ff @(posedge clk) begin
    if (s2_r && adv) begin
      sum_r <= sum; s3_last_r <= s2_last_r;
    end
  end

  // scale, truncate, clamp into output register
  logic [39:0] prod;
  logic [7:0] res;
  always_comb begin
    prod = 40'(unsigned'(sum_r)) * 40'(scale_r);
    if (sum_r <= 0) res = 8'd0;
    else if (prod[39:8] > 32'd255) res = 8'd255;
    else res = prod[15:8];
  end

  logic [7:0] opix_r;
  logic olast_r;
  always_ff @(posedge clk) begin
    if (s3_r && adv) begin
      opix_r <= res; olast_r <= s3_last_r;
    end
  end

  // advance pipeline valids
  always_comb begin
    s1_nxt = adv ? step : s1_r;
    s2_nxt = adv ? (s1_r && s1_emit_r) : s2_r;
    s3_nxt = adv ? s2_r : s3_r;
    ov_nxt = (s3_r && adv) ? 1'b1 : ((out_ch.ready) ? 1'b0 : ov_r);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= 1'b0; s2_r <= 1'b0; s3_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      s1_r <= s1_nxt; s2_r <= s2_nxt; s3_r <= s3_nxt; ov_r <= ov_nxt;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.pixel_out = opix_r;
  assign out_ch.frame_last = olast_r;

  `ICC_ASSERT_NEXT(a_counters_clear, clk, rst_n, step && emit && last, ~|{in_row_r, out_row_r})
  `ICC_ASSERT_NEXT(a_out_hold, clk, rst_n, ov_r && !out_ch.ready, ov_r)
  `ICC_ASSERT_IMPL(a_no_pass_when_stalled, clk, rst_n, ov_r && !out_ch.ready && s3_r, !in_ch.ready)
endmodule

// ----- dv/icc_conv_checker.sv -----
module icc_conv_checker (
  input  logic clk,
  input  logic rst_n,
  icc_in_if    in_ch,
  icc_out_if   out_ch,
  icc_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending,
  output int   result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KernelDim = icc_pkg::KernelDim;
  localparam int MaxWidth  = icc_pkg::MaxWidth;
  localparam int Kc        = icc_pkg::Kc;
  localparam int LineSlots = icc_pkg::LineSlots;

  typedef struct {
    logic [7:0] pixel;
    logic       last;
  } conv_result_t;

  conv_result_t expected_q[$];

  logic [11:0] width_reg;
  logic [15:0] height_reg;
  logic [15:0] scale_reg;
  logic [39:0] krow [5];

  logic [7:0] line_mem [LineSlots*MaxWidth];
  logic [7:0] win [KernelDim][KernelDim];
  int in_col, in_row, out_col, out_row;

  // signed coefficient k of kernel row r
  function automatic int coeff(int r, int k);
    logic [39:0] v;
    v = krow[r];
    return int'($signed(v[8*k +: 8]));
  endfunction

  // advance the raster and push the expected pixel, if any
  task automatic convolve_pixel(logic mode, logic [7:0] pix);
    int w, h, col, ocol, r, ry, cx;
    logic done, emit, last;
    logic [7:0] v, res;
    longint acc, prod;
    w = (width_reg == 0) ? 1 : ((width_reg > MaxWidth) ? MaxWidth : int'(width_reg));
    h = (height_reg == 0) ? 1 : int'(height_reg);
    done = (in_row >= h);
    if (mode && !done) return;
    v = done ? 8'd0 : pix;
    col = (in_col >= w) ? w - 1 : in_col;

    // shift the window left and load the new column
    for (int i = 0; i < KernelDim; i++)
      for (int j = 0; j + 1 < KernelDim; j++)
        win[i][j] = win[i][j+1];
    for (int i = 0; i < LineSlots; i++) begin
      r = in_row - LineSlots + i;
      win[i][KernelDim-1] = (r >= 0 && r < h) ? line_mem[(r % LineSlots)*MaxWidth + col] : 8'd0;
    end
    win[KernelDim-1][KernelDim-1] = v;
    line_mem[(in_row % LineSlots)*MaxWidth + col] = v;

    emit = (longint'(in_row) * w + col) >= (longint'(Kc) * w + Kc);
    if (emit) begin
      ocol = (out_col >= w) ? w - 1 : out_col;
      acc = 0;
      for (int i = 0; i < KernelDim; i++) begin
        ry = out_row + i - Kc;
        if (ry < 0 || ry >= h) continue;
        for (int j = 0; j < KernelDim; j++) begin
          cx = ocol + j - Kc;
          if (cx < 0 || cx >= w) continue;
          acc += longint'(win[i][j]) * coeff(KernelDim-1-i, KernelDim-1-j);
        end
      end
      res = 8'd0;
      if (acc > 0) begin
        prod = (acc * longint'(scale_reg)) >>> 8;
        res = (prod > 255) ? 8'd255 : prod[7:0];
      end
      last = (out_row >= h - 1) && (ocol >= w - 1);
      expected_q.push_back('{pixel: res, last: last});
      if (last) begin
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        return;
      end
      if (ocol + 1 >= w) begin
        out_col = 0;
        out_row++;
      end else begin
        out_col = ocol + 1;
      end
    end
    if (col + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col = col + 1;
    end
  endtask

  task automatic note_mismatch(string what, int exp_v, int act_v);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch %0t: %s expected %0d actual %0d", $realtime, what, exp_v, act_v);
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    conv_result_t want;
    if (!rst_n) begin
      width_reg = 12'd640;
      height_reg = 16'd480;
      scale_reg = 16'd256;
      krow[0] = 40'd16776447;
      krow[1] = 40'd16520444;
      krow[2] = 40'd16776447;
      krow[3] = '0;
      krow[4] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      expected_q.delete();
    end else begin
      // track register writes
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (icc_pkg::reg_idx_t'(cfg_ch.index))
          icc_pkg::REG_WIDTH:  width_reg = cfg_ch.data[11:0];
          icc_pkg::REG_HEIGHT: height_reg = cfg_ch.data[15:0];
          icc_pkg::REG_SCALE:  scale_reg = cfg_ch.data[15:0];
          icc_pkg::REG_KROW0:  krow[0] = cfg_ch.data;
          icc_pkg::REG_KROW1:  krow[1] = cfg_ch.data;
          icc_pkg::REG_KROW2:  krow[2] = cfg_ch.data;
          icc_pkg::REG_KROW3:  krow[3] = cfg_ch.data;
          icc_pkg::REG_KROW4:  krow[4] = cfg_ch.data;
          default: ;
        endcase
      end
      // compare each result transaction with the oldest expectation
      if (out_ch.valid && out_ch.ready) begin
        result_count++;
        if (expected_q.size() == 0) begin
          note_mismatch("unexpected result, pixel", -1, int'(out_ch.pixel_out));
        end else begin
          want = expected_q.pop_front();
          if (out_ch.pixel_out !== want.pixel)
            note_mismatch("pixel_out", int'(want.pixel), int'(out_ch.pixel_out));
          if (out_ch.frame_last !== want.last)
            note_mismatch("frame_last", int'(want.last), int'(out_ch.frame_last));
        end
      end
      if (in_ch.valid && in_ch.ready)
        convolve_pixel(in_ch.mode, in_ch.pixel_in);
    end
    pending = expected_q.size();
  end
endmodule

// ----- dv/image_convolution_clamp_top_test.sv -----
module image_convolution_clamp_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int fail_count, pending, result_count;
  int item_count = 0;
  int frame_count = 0;
  int cycles = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;

  icc_in_if  in_ch (clk);
  icc_out_if out_ch (clk);
  icc_cfg_if cfg_ch (clk);

  image_convolution_clamp_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  icc_conv_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count)
  );

  always #4 clk = ~clk;

  // bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver stalls at random
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= out_idle_pct);
  end

  task automatic write_reg(icc_pkg::reg_idx_t idx, logic [39:0] d);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // one input transaction; called and returns at a falling edge
  task automatic send_item(logic m, logic [7:0] p);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.mode = m;
    in_ch.pixel_in = p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    in_ch.valid = 1'b0;
    item_count++;
  endtask

  // hold off until every result is back and the pipeline is empty
  task automatic settle();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [39:0] rand_krow();
    logic [39:0] k;
    if ($urandom_range(1)) begin
      k = {8'($urandom), 32'($urandom)};
    end else begin
      for (int i = 0; i < 5; i++) k[8*i +: 8] = 8'($urandom_range(8) - 4);
    end
    return k;
  endfunction

  // one image: pixels with stray drains, then drains (some as late pixels)
  task automatic run_frame(int w_reg, int h_reg);
    int w, h;
    w = (w_reg == 0) ? 1 : ((w_reg > icc_pkg::MaxWidth) ? icc_pkg::MaxWidth : w_reg);
    h = (h_reg == 0) ? 1 : h_reg;
    write_reg(icc_pkg::REG_WIDTH, 40'(w_reg));
    write_reg(icc_pkg::REG_HEIGHT, 40'(h_reg));
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(29) == 0) send_item(1'b1, 8'($urandom));
      send_item(1'b0, rand_pixel());
    end
    for (int i = 0; i <= w; i++)
      send_item(($urandom_range(3) != 0), 8'($urandom));
    if ($urandom_range(3) == 0) send_item(1'b1, 8'($urandom));
    frame_count++;
    settle();
  endtask

  task automatic rand_kernel();
    case ($urandom_range(3))
      0: write_reg(icc_pkg::REG_SCALE, 40'd0);
      1: write_reg(icc_pkg::REG_SCALE, 40'd65535);
      2: write_reg(icc_pkg::REG_SCALE, 40'd256);
      default: write_reg(icc_pkg::REG_SCALE, 40'($urandom_range(1023)));
    endcase
    write_reg(icc_pkg::REG_KROW0, rand_krow());
    write_reg(icc_pkg::REG_KROW1, rand_krow());
    write_reg(icc_pkg::REG_KROW2, rand_krow());
    write_reg(icc_pkg::REG_KROW3, rand_krow());
    write_reg(icc_pkg::REG_KROW4, rand_krow());
  endtask

  initial begin
    int w, h, goal;
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.pixel_in = 8'd0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = icc_pkg::REG_WIDTH;
    cfg_ch.data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      in_idle_pct = (phase == 0) ? 25 : ((phase == 1) ? 68 : 0);
      out_idle_pct = (phase == 0) ? 68 : ((phase == 1) ? 25 : 0);
      if (phase == 0) begin
        // drain ahead of any image, then a 3x3 with the reset Laplacian
        send_item(1'b1, 8'hFF);
        run_frame(3, 3);
        // saturate both ways: all coefficients at the signed extremes
        write_reg(icc_pkg::REG_SCALE, 40'd65535);
        write_reg(icc_pkg::REG_KROW0, {5{8'h7F}});
        write_reg(icc_pkg::REG_KROW1, {5{8'h7F}});
        write_reg(icc_pkg::REG_KROW2, {5{8'h80}});
        run_frame(2, 2);
        write_reg(icc_pkg::REG_SCALE, 40'd0);
        run_frame(0, 0);
      end
      goal = item_count + 330;
      while (item_count < goal) begin
        rand_kernel();
        w = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
        h = $urandom_range(1, 6);
        run_frame(w, h);
      end
      if (phase == 2) begin
        // one long row and one tall column, unstalled
        rand_kernel();
        run_frame(64, 1);
        run_frame(1, 80);
      end
    end

    settle();
    $display("covered %0d input items in %0d images, %0d results checked",
             item_count, frame_count, result_count);
    $display("widths 0..64 and heights 0..80 with random kernels and scales");
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
